>>> rtl/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg
// shared types and constants of the fractional delay line
// ----------------------------------------------------------------------------
package fdl_pkg;

    localparam int DEPTH      = 1024;
    localparam int SAMPLE_W   = 24;
    localparam int DELAY_W    = 10;
    localparam int FRAC_W     = 16;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = (DELAY_W > FRAC_W) ? DELAY_W : FRAC_W;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int PROD_W     = SAMPLE_W + 1 + FRAC_W + 1;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_DELAY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAC  = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SAMPLE_W:0]   diff_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [DELAY_W-1:0]         delay_t;
    typedef logic [FRAC_W-1:0]          frac_t;
    typedef logic [QCNT_W-1:0]          qcnt_t;

    // one job handed from front to back: older tap and newer-minus-older
    typedef struct packed {
        sample_t a;
        diff_t   diff;
    } job_t;

    // sample store access issued by the front
    typedef struct packed {
        logic    we;
        addr_t   waddr;
        sample_t wdata;
        logic    re;
        addr_t   raddr_a;
        addr_t   raddr_b;
    } ram_req_t;

    function automatic addr_t sat_delay(input delay_t d);
        if (int'(d) > DEPTH - 1)
        begin
            return addr_t'(DEPTH - 1);
        end
        return addr_t'(d);
    endfunction

endpackage

>>> rtl/fdl_ram.sv
// ----------------------------------------------------------------------------
// fdl_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module fdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> rtl/fdl_front.sv
// ----------------------------------------------------------------------------
// fdl_front
// accepts samples, drives the sample store and builds interpolation jobs
// ----------------------------------------------------------------------------
module fdl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  fdl_pkg::sample_t  sample_in,
    input  fdl_pkg::delay_t   delay_samples,
    input  fdl_pkg::qcnt_t    q_level,
    output fdl_pkg::ram_req_t ram_req,
    input  fdl_pkg::sample_t  rdata_a,
    input  fdl_pkg::sample_t  rdata_b,
    output logic              job_push,
    output fdl_pkg::job_t     job
);
    import fdl_pkg::*;

    logic                accept;
    logic                bypass;
    addr_t               d_sat;
    addr_t               rd;
    addr_t               nx;
    logic [ADDR_W:0]     rd_wide;
    logic [QCNT_W:0]     level;

    addr_t               wp_reg;
    addr_t               wp_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                s1_valid_reg;
    logic                s1_bypass_reg;
    logic                s1_fwd_reg;
    logic                s1_a_ok_reg;
    logic                s1_b_ok_reg;
    sample_t             s1_sample_reg;

    sample_t             tap_a;
    sample_t             tap_b;

    assign level  = {1'b0, q_level} + (QCNT_W + 1)'(s1_valid_reg);
    assign full   = (level >= (QCNT_W + 1)'(QDEPTH));
    assign accept = push && !full;
    assign bypass = (delay_samples == '0);
    assign d_sat  = sat_delay(delay_samples);

    // read position wraps around the store
    always_comb
    begin
        if (wp_reg >= d_sat)
        begin
            rd_wide = {1'b0, wp_reg} - {1'b0, d_sat};
        end
        else
        begin
            rd_wide = {1'b0, wp_reg} + (ADDR_W + 1)'(DEPTH) - {1'b0, d_sat};
        end
        rd = rd_wide[ADDR_W-1:0];
        nx = (rd == addr_t'(DEPTH - 1)) ? '0 : rd + addr_t'(1);
    end

    assign wp_next   = (wp_reg == addr_t'(DEPTH - 1)) ? '0 : wp_reg + addr_t'(1);
    assign fill_next = (fill_reg == FILL_W'(DEPTH)) ? fill_reg : fill_reg + FILL_W'(1);

    assign ram_req.we      = accept && !bypass;
    assign ram_req.waddr   = wp_reg;
    assign ram_req.wdata   = sample_in;
    assign ram_req.re      = accept && !bypass;
    assign ram_req.raddr_a = rd;
    assign ram_req.raddr_b = nx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept && !bypass)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bypass_reg <= bypass;
            s1_sample_reg <= sample_in;
            s1_fwd_reg    <= (d_sat == addr_t'(1));
            s1_a_ok_reg   <= (FILL_W'(rd) < fill_reg);
            s1_b_ok_reg   <= (FILL_W'(nx) < fill_reg);
        end
    end

    // entries never written read as zero; delay of one takes the new sample
    always_comb
    begin
        if (s1_bypass_reg)
        begin
            tap_a = s1_sample_reg;
            tap_b = s1_sample_reg;
        end
        else
        begin
            tap_a = s1_a_ok_reg ? rdata_a : '0;
            if (s1_fwd_reg)
            begin
                tap_b = s1_sample_reg;
            end
            else
            begin
                tap_b = s1_b_ok_reg ? rdata_b : '0;
            end
        end
    end

    assign job_push = s1_valid_reg;
    assign job.a    = tap_a;
    assign job.diff = diff_t'(tap_b) - diff_t'(tap_a);

endmodule

>>> rtl/fdl_queue.sv
// ----------------------------------------------------------------------------
// fdl_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module fdl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  fdl_pkg::job_t  wr_job,
    input  logic           rd,
    output logic           valid,
    output fdl_pkg::job_t  head,
    output fdl_pkg::qcnt_t level
);
    import fdl_pkg::*;

    job_t                slot [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    qcnt_t               count_reg;
    logic                do_rd;

    assign valid = (count_reg != '0);
    assign head  = slot[rd_ptr_reg];
    assign level = count_reg;
    assign do_rd = rd && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
            end
            if (wr && !do_rd)
            begin
                count_reg <= count_reg + qcnt_t'(1);
            end
            else if (do_rd && !wr)
            begin
                count_reg <= count_reg - qcnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> rtl/fdl_back.sv
// ----------------------------------------------------------------------------
// fdl_back
// linear blend of the two taps with round to nearest, output register
// ----------------------------------------------------------------------------
module fdl_back (
    input  logic             clk,
    input  logic             rst_n,
    input  fdl_pkg::frac_t   interp_fraction,
    input  logic             q_valid,
    input  fdl_pkg::job_t    q_head,
    output logic             q_rd,
    output logic             empty,
    input  logic             pop,
    output fdl_pkg::sample_t sample_out
);
    import fdl_pkg::*;

    logic                       p1_valid_reg;
    sample_t                    p1_a_reg;
    logic signed [PROD_W-1:0]   p1_prod_reg;
    logic                       out_valid_reg;
    sample_t                    out_sample_reg;

    logic                       out_take;
    logic                       p1_adv;
    logic                       p1_take;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W:0]     rounded;
    logic signed [PROD_W-FRAC_W:0] step;
    logic signed [PROD_W-FRAC_W:0] sum;

    assign out_take = !out_valid_reg || pop;
    assign p1_adv   = p1_valid_reg && out_take;
    assign p1_take  = !p1_valid_reg || out_take;
    assign q_rd     = q_valid && p1_take;

    assign prod    = PROD_W'($signed(q_head.diff) * $signed({1'b0, interp_fraction}));
    assign rounded = (PROD_W + 1)'(p1_prod_reg) + (PROD_W + 1)'(ROUND_HALF);
    assign step    = rounded[PROD_W:FRAC_W];
    assign sum     = (PROD_W - FRAC_W + 1)'(p1_a_reg) + step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_take)
            begin
                p1_valid_reg <= q_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            p1_a_reg    <= q_head.a;
            p1_prod_reg <= prod;
        end
        if (p1_adv)
        begin
            out_sample_reg <= sum[SAMPLE_W-1:0];
        end
    end

    assign empty      = !out_valid_reg;
    assign sample_out = out_sample_reg;

endmodule

>>> rtl/fractional_delay_line.sv
// path: store read stage, job queue, product register, output register
// throughput: one sample per cycle while full is low, set by the dual-read sample store
// and the single blend multiplier
// reset: pointers, fill count, queue and both registers clear; store entries
// not yet written since reset read as zero, so no clearing pass is needed
// ----------------------------------------------------------------------------
// fractional_delay_line
// delay line with linear interpolation between two adjacent taps
// ----------------------------------------------------------------------------
module fractional_delay_line (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  fdl_pkg::sample_t             sample_in,
    output logic                         empty,
    input  logic                         pop,
    output fdl_pkg::sample_t             sample_out,
    input  logic                         cfg_write,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fdl_pkg::*;

    delay_t   delay_reg;
    frac_t    frac_reg;
    ram_req_t ram_req;
    sample_t  rdata_a;
    sample_t  rdata_b;
    logic     job_push;
    job_t     job;
    logic     q_valid;
    job_t     q_head;
    logic     q_rd;
    qcnt_t    q_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            frac_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DELAY: delay_reg <= cfg_data[DELAY_W-1:0];
                REG_FRAC:  frac_reg  <= cfg_data[FRAC_W-1:0];
                default:   ;
            endcase
        end
    end

    fdl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .sample_in     (sample_in),
        .delay_samples (delay_reg),
        .q_level       (q_level),
        .ram_req       (ram_req),
        .rdata_a       (rdata_a),
        .rdata_b       (rdata_b),
        .job_push      (job_push),
        .job           (job)
    );

    fdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (ram_req.wdata),
        .re      (ram_req.re),
        .raddr_a (ram_req.raddr_a),
        .raddr_b (ram_req.raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    fdl_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (job),
        .rd     (q_rd),
        .valid  (q_valid),
        .head   (q_head),
        .level  (q_level)
    );

    fdl_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .interp_fraction (frac_reg),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_rd            (q_rd),
        .empty           (empty),
        .pop             (pop),
        .sample_out      (sample_out)
    );

endmodule
